FILE: design/point_polar_and_rotate_macros.svh
// Assertion helpers used by the checker file.
`ifndef POINT_POLAR_AND_ROTATE_MACROS_SVH
`define POINT_POLAR_AND_ROTATE_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define PPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define PPR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: design/pprot_pkg.sv
package pprot_pkg;

  localparam int CB        = 24;               // coordinate width
  localparam int GUARD_BITS = 8;
  localparam int DW        = CB + GUARD_BITS + 3;
  localparam int STEPS     = 16;               // CORDIC stages per pass
  localparam int STEP_W    = 5;
  localparam int ANG_W     = 32;
  localparam int TURN_W    = 16;
  localparam int PA_W      = 16;
  localparam int MUL_W     = 32;
  localparam int LO_W      = DW / 2;
  localparam int HI_W      = DW - LO_W;

  localparam logic [MUL_W-1:0] INV_GAIN  = 32'd2608131496;
  localparam logic [ANG_W-1:0] HALF_TURN = ANG_W'(1) << (ANG_W - 1);
  localparam logic [ANG_W-1:0] PA_RND    = ANG_W'(1) << (ANG_W - PA_W - 1);
  localparam int               RND_HALF  = 1 << (GUARD_BITS - 1);

  typedef enum logic {
    MODE_VECTOR,
    MODE_ROTATE
  } mode_e;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic [ANG_W-1:0]     z;
    logic [TURN_W-1:0]    turn;
    logic [CB-1:0]        radius;
    logic [PA_W-1:0]      pangle;
    logic                 origin;
  } vec_t;

  // round(atan(2^-i) / (2 pi) * 2^32)
  function automatic logic [ANG_W-1:0] atan_turn(input logic [STEP_W-1:0] idx);
    logic [ANG_W-1:0] a;
    unique case (idx)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      5'd24: a = 32'd41;
      5'd25: a = 32'd20;
      5'd26: a = 32'd10;
      5'd27: a = 32'd5;
      5'd28: a = 32'd3;
      5'd29: a = 32'd1;
      5'd30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

FILE: design/pprot_cell.sv
module pprot_cell import pprot_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mode_e             mode_i,
  input  logic [STEP_W-1:0] step_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  vec_t              vec_i,
  output logic              valid_o,
  input  logic              ready_i,
  output vec_t              vec_o
);

  logic                 valid_q;
  vec_t                 vec_q, vec_d;
  logic signed [DW-1:0] xi, yi, xs, ys;
  logic [ANG_W-1:0]     at;
  logic                 up;

  always_comb begin
    xi = vec_i.x;
    yi = vec_i.y;
    xs = xi >>> step_i;
    ys = yi >>> step_i;
    at = atan_turn(step_i);
    // vectoring steers on the sign of y, rotation on the sign of the residual angle
    up = (mode_i == MODE_ROTATE) ? !vec_i.z[ANG_W-1] : yi[DW-1];
    vec_d = vec_i;
    if (up) begin
      vec_d.x = xi - ys;
      vec_d.y = yi + xs;
      vec_d.z = vec_i.z - at;
    end else begin
      vec_d.x = xi + ys;
      vec_d.y = yi - xs;
      vec_d.z = vec_i.z + at;
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign vec_o   = vec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      vec_q <= vec_d;
    end
  end

endmodule

FILE: design/pprot_gain.sv
module pprot_gain import pprot_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  vec_t vec_i,
  output logic valid_o,
  input  logic ready_i,
  output vec_t vec_o
);

  // x scaled by the inverse CORDIC gain, floored; split into two partial products
  logic                      a_vld_q, b_vld_q, b_rdy;
  vec_t                      a_q, b_q, b_d;
  logic [DW-1:0]             xu;
  logic [LO_W+MUL_W-1:0]     plo_d, plo_q;
  logic [HI_W+MUL_W-1:0]     phi_d, phi_q;
  logic [DW+MUL_W-1:0]       sum;

  always_comb begin
    xu    = vec_i.x;
    plo_d = (LO_W+MUL_W)'(xu[LO_W-1:0]) * (LO_W+MUL_W)'(INV_GAIN);
    phi_d = (HI_W+MUL_W)'(xu[DW-1:LO_W]) * (HI_W+MUL_W)'(INV_GAIN);
    sum   = {phi_q, LO_W'(0)} + (DW+MUL_W)'(plo_q);
    b_d   = a_q;
    b_d.x = sum[DW+MUL_W-1:MUL_W];
  end

  assign b_rdy   = !b_vld_q || ready_i;
  assign ready_o = !a_vld_q || b_rdy;
  assign valid_o = b_vld_q;
  assign vec_o   = b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      if (ready_o) begin
        a_vld_q <= valid_i;
      end
      if (b_rdy) begin
        b_vld_q <= a_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      a_q   <= vec_i;
      plo_q <= plo_d;
      phi_q <= phi_d;
    end
    if (b_rdy && a_vld_q) begin
      b_q <= b_d;
    end
  end

endmodule

FILE: design/point_polar_and_rotate.sv
// Pipeline, in order: entry register, vectoring row of STEPS CORDIC cells,
// two two-stage gain multipliers, rotation row of STEPS cells, output register.
// Throughput: one item per cycle while not stalled; each stage registers and moves alone.
// Reset: rst_ni, asynchronous and active low, clears every valid flag; payload
// registers keep whatever they held and are reloaded with the next item.
module point_polar_and_rotate import pprot_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [CB-1:0]  x_in_i,
  input  logic signed [CB-1:0]  y_in_i,
  input  logic [TURN_W-1:0]     turn_angle_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CB-1:0]         radius_o,
  output logic [PA_W-1:0]       polar_angle_o,
  output logic signed [CB:0]    rot_x_o,
  output logic signed [CB:0]    rot_y_o
);

  localparam int RW = DW + 1 - GUARD_BITS;
  localparam logic [CB-1:0] RAD_MAX = '1;
  localparam logic signed [RW-1:0] LIM_P = RW'((1 << CB) - 1);
  localparam logic signed [RW-1:0] LIM_N = -LIM_P;

  // Round from the guard scale (add half an LSB, floor) and clamp to +-(2^CB - 1).
  function automatic logic [CB:0] sat_out(input logic signed [DW-1:0] v);
    logic signed [DW:0]   vr;
    logic signed [RW-1:0] r;
    vr = {v[DW-1], v} + (DW+1)'(RND_HALF);
    r  = vr[DW:GUARD_BITS];
    if (r > LIM_P) begin
      r = LIM_P;
    end else if (r < LIM_N) begin
      r = LIM_N;
    end
    return r[CB:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Entry stage: lift the point to the guard scale, fold the left half-plane
  // onto the right one by half a turn, and flag the origin.
  // ---------------------------------------------------------------------------
  logic                 in_vld_q, in_rdy;
  vec_t                 in_q, in_d;
  logic signed [DW-1:0] xg, yg;

  always_comb begin
    xg = DW'(x_in_i) <<< GUARD_BITS;
    yg = DW'(y_in_i) <<< GUARD_BITS;
    in_d        = '0;
    in_d.turn   = turn_angle_i;
    in_d.origin = (x_in_i == '0) && (y_in_i == '0);
    if (x_in_i[CB-1]) begin
      in_d.x = -xg;
      in_d.y = -yg;
      in_d.z = HALF_TURN;
    end else begin
      in_d.x = xg;
      in_d.y = yg;
    end
  end

  // ---------------------------------------------------------------------------
  // Vectoring row: drive y to zero, accumulate the polar angle in z.
  // ---------------------------------------------------------------------------
  logic v_vld [STEPS+1];
  logic v_rdy [STEPS+1];
  vec_t v_vec [STEPS+1];

  assign in_rdy     = !in_vld_q || v_rdy[0];
  assign in_stall_o = !in_rdy;
  assign v_vld[0]   = in_vld_q;
  assign v_vec[0]   = in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_rdy) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && in_valid_i) begin
      in_q <= in_d;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_vec
    pprot_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .mode_i  (MODE_VECTOR),
      .step_i  (STEP_W'(i)),
      .valid_i (v_vld[i]),
      .ready_o (v_rdy[i]),
      .vec_i   (v_vec[i]),
      .valid_o (v_vld[i+1]),
      .ready_i (v_rdy[i+1]),
      .vec_o   (v_vec[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // First gain correction gives the scaled radius; derive the radius output and
  // the rounded polar angle here, then correct once more for the rotation pass.
  // ---------------------------------------------------------------------------
  logic          g1_vld, g1_rdy, g2_vld, g2_rdy;
  vec_t          g1_vec, g2_in, g2_vec;
  logic [DW:0]   rsum;
  logic [RW-1:0] rad_w;
  logic [ANG_W-1:0] pa_sum;

  pprot_gain u_gain_rad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_vld[STEPS]),
    .ready_o (v_rdy[STEPS]),
    .vec_i   (v_vec[STEPS]),
    .valid_o (g1_vld),
    .ready_i (g1_rdy),
    .vec_o   (g1_vec)
  );

  always_comb begin
    rsum   = {1'b0, g1_vec.x} + (DW+1)'(RND_HALF);
    rad_w  = rsum[DW:GUARD_BITS];
    pa_sum = g1_vec.z + PA_RND;
    g2_in  = g1_vec;
    // saturate the radius; a wrap of the angle to a full turn reads as zero
    g2_in.radius = (|rad_w[RW-1:CB]) ? RAD_MAX : rad_w[CB-1:0];
    g2_in.pangle = pa_sum[ANG_W-1:ANG_W-PA_W];
  end

  pprot_gain u_gain_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (g1_vld),
    .ready_o (g1_rdy),
    .vec_i   (g2_in),
    .valid_o (g2_vld),
    .ready_i (g2_rdy),
    .vec_o   (g2_vec)
  );

  // ---------------------------------------------------------------------------
  // Rotation row: start from (radius, 0) at polar angle plus turn angle. Targets
  // in the left half-plane start from the negated vector with half a turn off.
  // ---------------------------------------------------------------------------
  logic r_vld [STEPS+1];
  logic r_rdy [STEPS+1];
  vec_t r_vec [STEPS+1];
  logic [ANG_W-1:0] zr;
  logic [1:0]       quad;
  vec_t             r_in;

  always_comb begin
    zr   = g2_vec.z + {g2_vec.turn, (ANG_W-TURN_W)'(0)};
    quad = zr[ANG_W-1:ANG_W-2];
    r_in   = g2_vec;
    r_in.y = '0;
    r_in.z = zr;
    if (quad == 2'b01 || quad == 2'b10) begin
      r_in.x = -g2_vec.x;
      r_in.z = zr - HALF_TURN;
    end
  end

  assign r_vld[0] = g2_vld;
  assign g2_rdy   = r_rdy[0];
  assign r_vec[0] = r_in;

  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    pprot_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .mode_i  (MODE_ROTATE),
      .step_i  (STEP_W'(i)),
      .valid_i (r_vld[i]),
      .ready_o (r_rdy[i]),
      .vec_i   (r_vec[i]),
      .valid_o (r_vld[i+1]),
      .ready_i (r_rdy[i+1]),
      .vec_o   (r_vec[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Output register: round the rotated point, force the origin to all zeros,
  // and hold the item while the consumer stalls.
  // ---------------------------------------------------------------------------
  logic              out_vld_q, out_rdy;
  logic [CB-1:0]     radius_q;
  logic [PA_W-1:0]   pangle_q;
  logic [CB:0]       rx_q, ry_q;
  vec_t              fin;

  assign fin          = r_vec[STEPS];
  assign out_rdy      = !out_vld_q || !out_stall_i;
  assign r_rdy[STEPS] = out_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_rdy) begin
      out_vld_q <= r_vld[STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && r_vld[STEPS]) begin
      if (fin.origin) begin
        radius_q <= '0;
        pangle_q <= '0;
        rx_q     <= '0;
        ry_q     <= '0;
      end else begin
        radius_q <= fin.radius;
        pangle_q <= fin.pangle;
        rx_q     <= sat_out(fin.x);
        ry_q     <= sat_out(fin.y);
      end
    end
  end

  assign out_valid_o   = out_vld_q;
  assign radius_o      = radius_q;
  assign polar_angle_o = pangle_q;
  assign rot_x_o       = rx_q;
  assign rot_y_o       = ry_q;

endmodule

FILE: design/pprot_checker.sv
`include "point_polar_and_rotate_macros.svh"

module pprot_checker import pprot_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [CB-1:0]        radius_o,
  input logic [PA_W-1:0]      polar_angle_o,
  input logic signed [CB:0]   rot_x_o,
  input logic signed [CB:0]   rot_y_o
);

  // no item can reach the output straight out of reset
  `PPR_ASSERT_RST(a_rst_clears_out, !rst_ni |=> !out_valid_o, "result valid just after reset")

  `PPR_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(radius_o) && $stable(polar_angle_o) && $stable(rot_x_o) && $stable(rot_y_o), "stalled item changed")

  // rotated coordinates clamp symmetrically, so the most negative code never shows
  `PPR_ASSERT(a_rot_x_sym, out_valid_o |-> !(rot_x_o[CB] && (rot_x_o[CB-1:0] == '0)), "rot_x outside clamp")

  `PPR_ASSERT(a_rot_y_sym, out_valid_o |-> !(rot_y_o[CB] && (rot_y_o[CB-1:0] == '0)), "rot_y outside clamp")

endmodule

bind point_polar_and_rotate pprot_checker u_pprot_checker (.*);

FILE: dv/point_polar_and_rotate_test.sv
// Self-checking bench for point_polar_and_rotate.
// Points go in on the input channel, and a local CORDIC model predicts radius,
// polar angle and the rotated point for every accepted item. Results are
// compared in order as they leave the result channel.
module point_polar_and_rotate_test;
  import pprot_pkg::CB;
  import pprot_pkg::TURN_W;
  import pprot_pkg::PA_W;

  // Bench timing and run shape
  localparam int RESET_CYCLES   = 8;
  localparam int CORDIC_STAGES  = 16;
  localparam int FRAC_GUARD     = 8;                      // guard bits inside the datapath
  localparam int PIPE_LATENCY   = 2 * CORDIC_STAGES + 6;
  localparam int TAIL_CYCLES    = PIPE_LATENCY + 20;
  localparam int RAND_PER_PHASE = 400;
  localparam int HOLDOFF_ITEMS  = 120;
  localparam int LONG_HOLD      = 150;
  localparam int CYCLE_LIMIT    = 300000;

  localparam longint unsigned GAIN_INV_Q32 = 64'd2608131496;   // 1/K in Q0.32
  localparam longint unsigned RAD_MAX      = (64'd1 << CB) - 1;
  localparam logic [31:0]     ANG_HALF     = 32'h8000_0000;
  localparam logic [31:0]     ANG_ROUND    = 32'h0000_8000;

  localparam logic signed [CB-1:0] COORD_MAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] COORD_MIN = {1'b1, {(CB-1){1'b0}}};
  localparam logic signed [CB-1:0] COORD_ONE = 24'sd65536;       // 1.0 in Q16

  typedef struct packed {
    logic [CB-1:0]        radius;
    logic [PA_W-1:0]      pangle;
    logic signed [CB:0]   rot_x;
    logic signed [CB:0]   rot_y;
  } polar_result_t;

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic [TURN_W-1:0]    turn;
    logic                 fixed_exp;   // expectation typed in the table
    polar_result_t        exp;
  } stim_row_t;

  typedef enum logic [2:0] {
    PH_DIRECTED,
    PH_SENDER_SLOW,
    PH_RECEIVER_SLOW,
    PH_HOLDOFF,
    PH_FREE
  } tb_phase_e;

  localparam polar_result_t AT_ORIGIN = '{radius: '0, pangle: '0, rot_x: '0, rot_y: '0};

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_stall_o;
  logic signed [CB-1:0]  x_in_i       = '0;
  logic signed [CB-1:0]  y_in_i       = '0;
  logic [TURN_W-1:0]     turn_angle_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i  = 1'b0;
  logic [CB-1:0]         radius_o;
  logic [PA_W-1:0]       polar_angle_o;
  logic signed [CB:0]    rot_x_o;
  logic signed [CB:0]    rot_y_o;

  polar_result_t pending_results[$];   // predicted results, oldest first
  tb_phase_e     phase          = PH_DIRECTED;
  int            send_idle_pct  = 0;
  int            recv_idle_pct  = 0;
  int            mismatches     = 0;
  int            points_sent    = 0;
  int            results_seen   = 0;
  int            cycle_cnt      = 0;

  point_polar_and_rotate i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .x_in_i        (x_in_i),
    .y_in_i        (y_in_i),
    .turn_angle_i  (turn_angle_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .radius_o      (radius_o),
    .polar_angle_o (polar_angle_o),
    .rot_x_o       (rot_x_o),
    .rot_y_o       (rot_y_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Arctangent of 2^-i as a 32-bit turn fraction.
  function automatic logic [31:0] atan_step(input int i);
    case (i)
      0:  return 32'd536870912;
      1:  return 32'd316933406;
      2:  return 32'd167458907;
      3:  return 32'd85004756;
      4:  return 32'd42667331;
      5:  return 32'd21354465;
      6:  return 32'd10679838;
      7:  return 32'd5340245;
      8:  return 32'd2670163;
      9:  return 32'd1335087;
      10: return 32'd667544;
      11: return 32'd333772;
      12: return 32'd166886;
      13: return 32'd83443;
      14: return 32'd41722;
      15: return 32'd20861;
      default: return 32'd0;
    endcase
  endfunction

  // Multiply by 1/K, flooring; split so the low partial product fits 64 bits.
  function automatic longint unsigned scale_inv_gain(input longint unsigned v);
    longint unsigned hi;
    longint unsigned lo;
    hi = v >> 32;
    lo = v & 64'hFFFF_FFFF;
    return hi * GAIN_INV_Q32 + ((lo * GAIN_INV_Q32) >> 32);
  endfunction

  // Drop the guard bits with round-half-up, then clamp symmetrically.
  function automatic logic signed [CB:0] round_coord(input longint v);
    longint r;
    longint lim;
    r   = (v + (64'sd1 <<< (FRAC_GUARD - 1))) >>> FRAC_GUARD;
    lim = (64'sd1 <<< CB) - 1;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[CB:0];
  endfunction

  // Vectoring pass for radius and angle, then a rotation pass that rebuilds
  // the point from (radius, angle + turn).
  function automatic polar_result_t cordic_polar_rotate(input logic signed [CB-1:0] px,
                                                         input logic signed [CB-1:0] py,
                                                         input logic [TURN_W-1:0]    turn);
    polar_result_t   res;
    longint          vx;
    longint          vy;
    longint          xs;
    longint          ys;
    longint unsigned rg;
    longint unsigned rad;
    logic [31:0]     ang;
    logic [31:0]     rnd;
    int              i;
    res = AT_ORIGIN;
    if (px == 0 && py == 0) return res;
    vx  = longint'(px) * (64'sd1 <<< FRAC_GUARD);
    vy  = longint'(py) * (64'sd1 <<< FRAC_GUARD);
    ang = '0;
    // Left half-plane: turn by half a turn first.
    if (vx < 0) begin
      vx  = -vx;
      vy  = -vy;
      ang = ANG_HALF;
    end
    for (i = 0; i < CORDIC_STAGES; i++) begin
      xs = vx >>> i;
      ys = vy >>> i;
      if (vy < 0) begin
        vx  = vx - ys;
        vy  = vy + xs;
        ang = ang - atan_step(i);
      end else begin
        vx  = vx + ys;
        vy  = vy - xs;
        ang = ang + atan_step(i);
      end
    end
    rg  = scale_inv_gain(longint'(unsigned'(vx)));
    rad = (rg + (64'd1 << (FRAC_GUARD - 1))) >> FRAC_GUARD;
    if (rad > RAD_MAX) rad = RAD_MAX;
    res.radius = rad[CB-1:0];
    // An angle rounding up to a full turn wraps to zero here.
    rnd        = ang + ANG_ROUND;
    res.pangle = rnd[31:16];

    ang = ang + {turn, 16'h0000};
    vx  = longint'(scale_inv_gain(rg));
    vy  = 0;
    // Second and third quadrants: start from the mirrored vector.
    if (ang[31:30] == 2'b01 || ang[31:30] == 2'b10) begin
      vx  = -vx;
      ang = ang - ANG_HALF;
    end
    for (i = 0; i < CORDIC_STAGES; i++) begin
      xs = vx >>> i;
      ys = vy >>> i;
      if (!ang[31]) begin
        vx  = vx - ys;
        vy  = vy + xs;
        ang = ang - atan_step(i);
      end else begin
        vx  = vx + ys;
        vy  = vy - xs;
        ang = ang + atan_step(i);
      end
    end
    res.rot_x = round_coord(vx);
    res.rot_y = round_coord(vy);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic stim_row_t mk_row(input logic signed [CB-1:0] x,
                                       input logic signed [CB-1:0] y,
                                       input logic [TURN_W-1:0]    t,
                                       input logic                 fixed,
                                       input polar_result_t        exp);
    stim_row_t r;
    r.x         = x;
    r.y         = y;
    r.turn      = t;
    r.fixed_exp = fixed;
    r.exp       = exp;
    return r;
  endfunction

  // Mostly full-range values; some shrunk towards zero, some on an axis or
  // at the extremes, so tiny vectors and corner points keep turning up.
  function automatic logic signed [CB-1:0] rand_coord();
    logic signed [CB-1:0] c;
    c = CB'($urandom);
    case ($urandom_range(9))
      6, 7: c = c >>> $urandom_range(CB - 1);
      8:    c = '0;
      9: begin
        case ($urandom_range(3))
          0:       c = COORD_MAX;
          1:       c = COORD_MIN;
          2:       c = 24'sd1;
          default: c = {CB{1'b1}};
        endcase
      end
      default: ;
    endcase
    return c;
  endfunction

  function automatic stim_row_t rand_row();
    return mk_row(rand_coord(), rand_coord(), TURN_W'($urandom_range(16'hFFFF)), 1'b0, '0);
  endfunction

  // Offer one item, idling first at the current rate, and hold it until taken.
  // Valid is left high on return; the next call or a drain decides its fate.
  task automatic send_point(input stim_row_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    x_in_i       <= r.x;
    y_in_i       <= r.y;
    turn_angle_i <= r.turn;
    do @(posedge clk_i); while (in_stall_o);
    if (r.fixed_exp) pending_results.push_back(r.exp);
    else pending_results.push_back(cordic_polar_rotate(r.x, r.y, r.turn));
    points_sent++;
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off to back the pipe up
  // ---------------------------------------------------------------------------

  initial begin : recv_stall
    int hold_left;
    bit holdoff_done;
    hold_left    = 0;
    holdoff_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (phase == PH_HOLDOFF && !holdoff_done) begin
        hold_left    = LONG_HOLD;
        holdoff_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_field(input string what, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    polar_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got radius %0d angle %0d rot %0d,%0d",
                 $time, radius_o, polar_angle_o, rot_x_o, rot_y_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        report_field("radius", want.radius, radius_o);
        report_field("polar_angle", want.pangle, polar_angle_o);
        report_field("rot_x", want.rot_x, rot_x_o);
        report_field("rot_y", want.rot_y, rot_y_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    stim_row_t directed_rows[$];
    int        n_directed;

    // Origin: everything zero, whatever the turn.
    directed_rows.push_back(mk_row('0, '0, 16'h0000, 1'b1, AT_ORIGIN));
    directed_rows.push_back(mk_row('0, '0, 16'hFFFF, 1'b1, AT_ORIGIN));
    // Unit vectors on each axis, quarter-turn rotations.
    directed_rows.push_back(mk_row(COORD_ONE, '0, 16'h0000, 1'b0, '0));
    directed_rows.push_back(mk_row('0, COORD_ONE, 16'h4000, 1'b0, '0));
    directed_rows.push_back(mk_row(-COORD_ONE, '0, 16'h8000, 1'b0, '0));
    directed_rows.push_back(mk_row('0, -COORD_ONE, 16'hC000, 1'b0, '0));
    // Corners of the coordinate range: largest radius.
    directed_rows.push_back(mk_row(COORD_MAX, COORD_MAX, 16'hFFFF, 1'b0, '0));
    directed_rows.push_back(mk_row(COORD_MIN, COORD_MIN, 16'h0000, 1'b0, '0));
    directed_rows.push_back(mk_row(COORD_MIN, COORD_MAX, 16'h2000, 1'b0, '0));
    directed_rows.push_back(mk_row(COORD_MAX, COORD_MIN, 16'hE000, 1'b0, '0));
    // Just below the positive x axis: angle rounds up to a full turn and wraps.
    directed_rows.push_back(mk_row(COORD_MAX, {CB{1'b1}}, 16'h0000, 1'b0, '0));
    directed_rows.push_back(mk_row(COORD_MAX, '0, 16'h0001, 1'b0, '0));
    // Negative x axis starts from half a turn; then both y axes.
    directed_rows.push_back(mk_row(COORD_MIN, '0, 16'h8000, 1'b0, '0));
    directed_rows.push_back(mk_row('0, COORD_MIN, 16'h7FFF, 1'b0, '0));
    directed_rows.push_back(mk_row('0, COORD_MAX, 16'h8001, 1'b0, '0));
    // Smallest non-zero vectors.
    directed_rows.push_back(mk_row(24'sd1, '0, 16'h1234, 1'b0, '0));
    directed_rows.push_back(mk_row('0, 24'sd1, 16'h0000, 1'b0, '0));
    directed_rows.push_back(mk_row({CB{1'b1}}, '0, 16'h0000, 1'b0, '0));
    directed_rows.push_back(mk_row({CB{1'b1}}, {CB{1'b1}}, 16'hFFFF, 1'b0, '0));
    directed_rows.push_back(mk_row(24'sd1, {CB{1'b1}}, 16'h4000, 1'b0, '0));
    // Left half-plane just either side of the negative x axis.
    directed_rows.push_back(mk_row(-COORD_ONE, {CB{1'b1}}, 16'h0000, 1'b0, '0));
    directed_rows.push_back(mk_row(-COORD_ONE, 24'sd1, 16'hAAAA, 1'b0, '0));
    n_directed = directed_rows.size();

    // Hold reset, then release it on a clock edge.
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the table with light sender idling and a busy receiver.
    phase         = PH_DIRECTED;
    send_idle_pct = 12;
    recv_idle_pct = 64;
    foreach (directed_rows[k]) send_point(directed_rows[k]);
    drain_results();

    // Random points: sender mostly busy, receiver stalls a lot.
    phase = PH_SENDER_SLOW;
    repeat (RAND_PER_PHASE) send_point(rand_row());
    drain_results();

    // Swap the roles: sender sparse, receiver mostly ready.
    phase         = PH_RECEIVER_SLOW;
    send_idle_pct = 64;
    recv_idle_pct = 12;
    repeat (RAND_PER_PHASE) send_point(rand_row());
    drain_results();

    // Receiver holds off for a long stretch while points keep coming,
    // so the pipe fills and the input stalls.
    phase         = PH_HOLDOFF;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (HOLDOFF_ITEMS) send_point(rand_row());
    drain_results();

    // Full rate on both sides.
    phase = PH_FREE;
    repeat (RAND_PER_PHASE) send_point(rand_row());
    drain_results();

    // Leave room for any stray result to show up.
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      mismatches += pending_results.size();
    end
    $display("covered %0d points (%0d from the table, rest random) over idle, stall",
             points_sent, n_directed);
    $display("and hold-off phases; %0d results checked, %0d mismatches", results_seen,
             mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/pprot_pkg.sv
design/pprot_cell.sv
design/pprot_gain.sv
design/point_polar_and_rotate.sv
design/pprot_checker.sv
dv/point_polar_and_rotate_test.sv
